@@ sv/bezier_curve_point_evaluator_defines.svh @@
// ----------------------------------------------------------------------------
// Bezier evaluator assertion macros
// Concurrent property wrappers shared by the evaluator RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_POINT_EVALUATOR_DEFINES_SVH
`define BEZIER_CURVE_POINT_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define BCE_ASSERT_IMPLY(name, clk_i, rstn_i, ante, cons, msg) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BCE_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons, msg) \
    name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BCE_ASSERT_IMPLY(name, clk_i, rstn_i, ante, cons, msg)

`define BCE_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons, msg)

`endif

`endif

@@ sv/bce_pkg.sv @@
// ----------------------------------------------------------------------------
// Bezier evaluator package
// Field widths, stream layout, opcodes and pipeline control types.
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

    // Store size default
    localparam int DEFAULT_POINT_COUNT = 16;

    // Field widths
    localparam int COORD_W  = 24;
    localparam int INDEX_W  = 4;
    localparam int DEGREE_W = 2;
    localparam int U_W      = 17;
    localparam int AXES     = 3;
    localparam int TERMS    = 4;
    localparam int POINT_W  = AXES * COORD_W;

    // Weight arithmetic: u^2 fits 33 bits, weights sum to 2^48
    localparam int SQ_W     = 33;
    localparam int WT_W     = 49;
    localparam int WT_LO_W  = 24;
    localparam int WT_HI_W  = WT_W - WT_LO_W;
    localparam int QUAD_SHIFT = 16;
    localparam int LIN_SHIFT  = 32;

    localparam logic [U_W-1:0]     U_ONE      = 17'h10000;
    localparam logic [WT_W-1:0]    WT_ONE     = {1'b1, {(WT_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] COORD_SIGN = {1'b1, {(COORD_W-1){1'b0}}};

    // Operations carried in s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Degree codes
    localparam logic [DEGREE_W-1:0] DEG_POINT  = 2'd0;
    localparam logic [DEGREE_W-1:0] DEG_LINEAR = 2'd1;
    localparam logic [DEGREE_W-1:0] DEG_QUAD   = 2'd2;
    localparam logic [DEGREE_W-1:0] DEG_CUBIC  = 2'd3;

    // Input tdata layout, lowest field first
    localparam int OFS_INDEX = 0;
    localparam int OFS_X     = OFS_INDEX + INDEX_W;
    localparam int OFS_Y     = OFS_X + COORD_W;
    localparam int OFS_Z     = OFS_Y + COORD_W;
    localparam int OFS_DEG   = OFS_Z + COORD_W;
    localparam int OFS_BASE  = OFS_DEG + DEGREE_W;
    localparam int OFS_U     = OFS_BASE + INDEX_W;
    localparam int IN_FIELDS_W = OFS_U + U_W;
    localparam int S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = POINT_W;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [WT_W-1:0]    weight_t;

    // Per-stage advance enables, first stage to last
    typedef struct packed {
        logic rd;
        logic sq;
        logic cu;
        logic wt;
        logic mul;
        logic sum;
        logic fin;
    } bce_adv_t;

endpackage

`default_nettype wire

@@ sv/bce_store.sv @@
// ----------------------------------------------------------------------------
// Control point store
// Four interleaved banks, one read port each, so that the four consecutive
// points of a segment are read together; read data is rotated into term order,
// converted to offset binary and masked beyond the segment degree or on error.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_store #(
    parameter int POINT_COUNT = bce_pkg::DEFAULT_POINT_COUNT
) (
    input  wire logic                                   clk,
    input  wire bce_pkg::bce_adv_t                      adv,
    input  wire logic                                   wr_en,
    input  wire logic [bce_pkg::INDEX_W-1:0]            wr_index,
    input  wire logic [bce_pkg::POINT_W-1:0]            wr_point,
    input  wire logic [bce_pkg::INDEX_W-1:0]            rd_base,
    input  wire logic [bce_pkg::DEGREE_W-1:0]           rd_degree,
    input  wire logic                                   rd_error,
    output logic [bce_pkg::TERMS-1:0][bce_pkg::AXES-1:0][bce_pkg::COORD_W-1:0] term_coord
);
    import bce_pkg::*;

    localparam int BANK_DEPTH = (POINT_COUNT + TERMS - 1) / TERMS;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int BANK_SEL_W = $clog2(TERMS);
    localparam int J_W        = INDEX_W + 1;

    logic [TERMS-1:0][POINT_W-1:0]                    bank_q;
    logic [BANK_AW-1:0]                               wr_addr;
    logic [BANK_SEL_W-1:0]                            base_lo_reg;
    logic [DEGREE_W-1:0]                              degree_reg;
    logic                                             error_reg;
    logic [2*TERMS*POINT_W-1:0]                       rot_wide;
    logic [TERMS-1:0][POINT_W-1:0]                    rot_next;
    logic [TERMS-1:0][AXES-1:0][COORD_W-1:0]          term_next;
    logic [TERMS-1:0][AXES-1:0][COORD_W-1:0]          term_reg;

    assign wr_addr = BANK_AW'(wr_index[INDEX_W-1:BANK_SEL_W]);

    // One bank per residue of the point index modulo four
    for (genvar b = 0; b < TERMS; b++) begin : g_bank
        logic [POINT_W-1:0]    bank_mem [BANK_DEPTH];
        logic [POINT_W-1:0]    rd_q_reg;
        logic [BANK_SEL_W-1:0] term_sel;
        logic [J_W-1:0]        point_j;
        logic [BANK_AW-1:0]    rd_addr;

        // Term of the segment that falls into this bank
        assign term_sel = BANK_SEL_W'(b) - rd_base[BANK_SEL_W-1:0];
        assign point_j  = {1'b0, rd_base} + J_W'(term_sel);
        assign rd_addr  = BANK_AW'(point_j[J_W-1:BANK_SEL_W]);

        always_ff @(posedge clk)
        begin
            if (wr_en && (wr_index[BANK_SEL_W-1:0] == BANK_SEL_W'(b)))
            begin
                bank_mem[wr_addr] <= wr_point;
            end
            if (adv.rd)
            begin
                rd_q_reg <= bank_mem[rd_addr];
            end
        end

        assign bank_q[b] = rd_q_reg;
    end

    // Hold segment alignment beside the read data
    always_ff @(posedge clk)
    begin
        if (adv.rd)
        begin
            base_lo_reg <= rd_base[BANK_SEL_W-1:0];
            degree_reg  <= rd_degree;
            error_reg   <= rd_error;
        end
    end

    // Rotate banks into term order, flip to offset binary, mask unused terms
    always_comb
    begin
        rot_wide = {bank_q, bank_q} >> (POINT_W * base_lo_reg);
        rot_next = rot_wide[TERMS*POINT_W-1:0];
        for (int i = 0; i < TERMS; i++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if ((BANK_SEL_W'(i) <= degree_reg) && !error_reg)
                begin
                    term_next[i][a] = rot_next[i][a*COORD_W +: COORD_W] ^ COORD_SIGN;
                end
                else
                begin
                    term_next[i][a] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.sq)
        begin
            term_reg <= term_next;
        end
    end

    assign term_coord = term_reg;

endmodule

`default_nettype wire

@@ sv/bce_weights.sv @@
// ----------------------------------------------------------------------------
// Bernstein weight pipeline
// Forms the scaled Bernstein weights of u and v = 1 - u over four stages:
// clamp, squares, cubes, then selection by degree. Weights sum to 2^48.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_weights (
    input  wire logic                                    clk,
    input  wire bce_pkg::bce_adv_t                       adv,
    input  wire logic [bce_pkg::U_W-1:0]                 u_param,
    input  wire logic [bce_pkg::DEGREE_W-1:0]            degree,
    output logic [bce_pkg::TERMS-1:0][bce_pkg::WT_W-1:0] weight
);
    import bce_pkg::*;

    localparam int SQ_FULL_W = 2 * U_W;
    localparam int CU_FULL_W = SQ_W + U_W;

    logic [U_W-1:0]      u_clamp;
    logic [U_W-1:0]      u1_reg, v1_reg;
    logic [DEGREE_W-1:0] deg1_reg, deg2_reg, deg3_reg;
    logic [SQ_FULL_W-1:0] uu_full, vv_full, uv_full;
    logic [SQ_W-1:0]     uu2_reg, vv2_reg, uv2_reg;
    logic [U_W-1:0]      u2_reg, v2_reg;
    logic [CU_FULL_W-1:0] uuu_full, uuv_full, uvv_full, vvv_full;
    logic [WT_W-1:0]     uuu3_reg, uuv3_reg, uvv3_reg, vvv3_reg;
    logic [SQ_W-1:0]     uu3_reg, vv3_reg, uv3_reg;
    logic [U_W-1:0]      u3_reg, v3_reg;
    logic [TERMS-1:0][WT_W-1:0] weight_next;
    logic [TERMS-1:0][WT_W-1:0] weight_reg;

    // Saturate u at one
    assign u_clamp = (u_param > U_ONE) ? U_ONE : u_param;

    always_ff @(posedge clk)
    begin
        if (adv.rd)
        begin
            u1_reg   <= u_clamp;
            v1_reg   <= U_ONE - u_clamp;
            deg1_reg <= degree;
        end
    end

    // Squares and cross term
    assign uu_full = u1_reg * u1_reg;
    assign vv_full = v1_reg * v1_reg;
    assign uv_full = u1_reg * v1_reg;

    always_ff @(posedge clk)
    begin
        if (adv.sq)
        begin
            uu2_reg  <= uu_full[SQ_W-1:0];
            vv2_reg  <= vv_full[SQ_W-1:0];
            uv2_reg  <= uv_full[SQ_W-1:0];
            u2_reg   <= u1_reg;
            v2_reg   <= v1_reg;
            deg2_reg <= deg1_reg;
        end
    end

    // Cubic products
    assign uuu_full = uu2_reg * u2_reg;
    assign uuv_full = uu2_reg * v2_reg;
    assign uvv_full = vv2_reg * u2_reg;
    assign vvv_full = vv2_reg * v2_reg;

    always_ff @(posedge clk)
    begin
        if (adv.cu)
        begin
            uuu3_reg <= uuu_full[WT_W-1:0];
            uuv3_reg <= uuv_full[WT_W-1:0];
            uvv3_reg <= uvv_full[WT_W-1:0];
            vvv3_reg <= vvv_full[WT_W-1:0];
            uu3_reg  <= uu2_reg;
            vv3_reg  <= vv2_reg;
            uv3_reg  <= uv2_reg;
            u3_reg   <= u2_reg;
            v3_reg   <= v2_reg;
            deg3_reg <= deg2_reg;
        end
    end

    // Select and scale weights by degree
    always_comb
    begin
        weight_next = '0;
        case (deg3_reg)
            DEG_CUBIC:
            begin
                weight_next[0] = vvv3_reg;
                weight_next[1] = (uvv3_reg << 1) + uvv3_reg;
                weight_next[2] = (uuv3_reg << 1) + uuv3_reg;
                weight_next[3] = uuu3_reg;
            end
            DEG_QUAD:
            begin
                weight_next[0] = WT_W'(vv3_reg) << QUAD_SHIFT;
                weight_next[1] = WT_W'(uv3_reg) << (QUAD_SHIFT + 1);
                weight_next[2] = WT_W'(uu3_reg) << QUAD_SHIFT;
            end
            DEG_LINEAR:
            begin
                weight_next[0] = WT_W'(v3_reg) << LIN_SHIFT;
                weight_next[1] = WT_W'(u3_reg) << LIN_SHIFT;
            end
            default:
            begin
                weight_next[0] = WT_ONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv.wt)
        begin
            weight_reg <= weight_next;
        end
    end

    assign weight = weight_reg;

endmodule

`default_nettype wire

@@ sv/bce_blend.sv @@
// ----------------------------------------------------------------------------
// Single-axis blend
// Multiplies four offset-binary coordinates by their weights as split
// partial products, sums them, rounds once to nearest and returns the
// two's complement coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module bce_blend (
    input  wire logic                                       clk,
    input  wire bce_pkg::bce_adv_t                          adv,
    input  wire logic [bce_pkg::TERMS-1:0][bce_pkg::COORD_W-1:0] coord_in,
    input  wire logic [bce_pkg::TERMS-1:0][bce_pkg::WT_W-1:0]    weight,
    input  wire logic                                       clear,
    output bce_pkg::coord_t                                 point
);
    import bce_pkg::*;

    localparam int PHI_W  = COORD_W + WT_HI_W;
    localparam int PLO_W  = COORD_W + WT_LO_W;
    localparam int SUM_GROW = $clog2(TERMS);
    localparam int HS_W   = PHI_W + SUM_GROW;
    localparam int LS_W   = PLO_W + SUM_GROW;
    localparam int TOT_W  = HS_W + WT_LO_W + 1;
    localparam int FRAC_W = 2 * WT_LO_W;
    localparam int Q_W    = TOT_W - FRAC_W;
    localparam logic [TOT_W-1:0] ROUND_HALF = TOT_W'(1) << (FRAC_W - 1);
    localparam logic [Q_W-1:0]   Q_MAX      = Q_W'({COORD_W{1'b1}});

    logic [TERMS-1:0][COORD_W-1:0] c3_reg, c4_reg;
    logic [TERMS-1:0][PHI_W-1:0]   phi_next, phi_reg;
    logic [TERMS-1:0][PLO_W-1:0]   plo_next, plo_reg;
    logic [HS_W-1:0]               hi_next, hi_reg;
    logic [LS_W-1:0]               lo_next, lo_reg;
    logic [TOT_W-1:0]              total;
    logic [Q_W-1:0]                q_wide;
    logic [COORD_W-1:0]            q_sat;
    logic [COORD_W-1:0]            point_reg;

    // Delay coordinates to meet the weights
    always_ff @(posedge clk)
    begin
        if (adv.cu)
        begin
            c3_reg <= coord_in;
        end
        if (adv.wt)
        begin
            c4_reg <= c3_reg;
        end
    end

    // Split partial products, upper and lower weight halves
    always_comb
    begin
        for (int i = 0; i < TERMS; i++)
        begin
            phi_next[i] = PHI_W'(c4_reg[i]) * PHI_W'(weight[i][WT_W-1:WT_LO_W]);
            plo_next[i] = PLO_W'(c4_reg[i]) * PLO_W'(weight[i][WT_LO_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.mul)
        begin
            phi_reg <= phi_next;
            plo_reg <= plo_next;
        end
    end

    // Sum the terms of each half
    always_comb
    begin
        hi_next = '0;
        lo_next = '0;
        for (int i = 0; i < TERMS; i++)
        begin
            hi_next = hi_next + HS_W'(phi_reg[i]);
            lo_next = lo_next + LS_W'(plo_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.sum)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    // Join halves, round half up, saturate, back to two's complement
    assign total  = {1'b0, hi_reg, {WT_LO_W{1'b0}}} + TOT_W'(lo_reg) + ROUND_HALF;
    assign q_wide = total[TOT_W-1:FRAC_W];
    assign q_sat  = (q_wide > Q_MAX) ? {COORD_W{1'b1}} : q_wide[COORD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv.fin)
        begin
            point_reg <= clear ? '0 : (q_sat ^ COORD_SIGN);
        end
    end

    assign point = point_reg;

endmodule

`default_nettype wire

@@ sv/bezier_curve_point_evaluator.sv @@
// ----------------------------------------------------------------------------
// Bezier curve point evaluator
// Takes one item per clock on the slave stream unless stalled. A write item
// (tuser 0) loads one 3D control point into the store and completes at its
// transfer; it yields no result. An evaluate item (tuser 1) returns the
// Bernstein point of degree 0 to 3 in signed Q16.8 on the master stream, with
// index_error set and zero coordinates when the segment runs past the store.
// Throughput is one item per cycle unless stalled: the store is split into
// four interleaved banks with one read port each, the weight and blend paths
// are seven register stages, and a stall holds each full stage while empty
// stages keep filling. A point must be written before a segment reads it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bezier_curve_point_evaluator_defines.svh"

module bezier_curve_point_evaluator #(
    parameter int POINT_COUNT = bce_pkg::DEFAULT_POINT_COUNT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // point_index, x_value, y_value, z_value, degree, base_index, u_param
    input  wire logic [bce_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // x_point, y_point, z_point
    output logic [bce_pkg::M_TDATA_W-1:0]        m_tdata,
    // index_error
    output logic                                 m_tuser
);
    import bce_pkg::*;

    localparam int STAGES = 7;
    localparam int CNT_W  = $clog2(POINT_COUNT + 1);
    localparam int SUM_W  = INDEX_W + 1;
    localparam int CMP_W  = (CNT_W > SUM_W) ? CNT_W : SUM_W;

    logic [INDEX_W-1:0]  point_index;
    logic [POINT_W-1:0]  point_value;
    logic [DEGREE_W-1:0] degree;
    logic [INDEX_W-1:0]  base_index;
    logic [U_W-1:0]      u_param;
    logic [SUM_W-1:0]    seg_end;
    logic                index_error;
    logic                wr_en;
    logic                in_xfer;

    logic [STAGES+1:1]   en;
    logic [STAGES:1]     valid_reg;
    logic [STAGES:1]     err_reg;
    bce_adv_t            adv;

    logic [TERMS-1:0][AXES-1:0][COORD_W-1:0] term_coord;
    logic [TERMS-1:0][WT_W-1:0]              weight;

    // Unpack the input transfer
    assign point_index = s_tdata[OFS_INDEX +: INDEX_W];
    assign point_value = s_tdata[OFS_X +: POINT_W];
    assign degree      = s_tdata[OFS_DEG +: DEGREE_W];
    assign base_index  = s_tdata[OFS_BASE +: INDEX_W];
    assign u_param     = s_tdata[OFS_U +: U_W];

    assign in_xfer     = s_tvalid && s_tready;
    assign seg_end     = {1'b0, base_index} + SUM_W'(degree);
    assign index_error = CMP_W'(seg_end) >= CMP_W'(POINT_COUNT);
    assign wr_en       = in_xfer && (s_tuser == OP_WRITE)
                         && (CMP_W'(point_index) < CMP_W'(POINT_COUNT));

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        en[STAGES+1] = m_tready;
        for (int k = STAGES; k >= 1; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign adv.rd  = en[1];
    assign adv.sq  = en[2];
    assign adv.cu  = en[3];
    assign adv.wt  = en[4];
    assign adv.mul = en[5];
    assign adv.sum = en[6];
    assign adv.fin = en[7];

    assign s_tready = en[1];

    // Valid bits; write items leave a bubble
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= s_tvalid && (s_tuser == OP_EVAL);
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Carry the segment error beside the data
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            err_reg[1] <= index_error;
        end
        for (int k = 2; k <= STAGES; k++)
        begin
            if (en[k])
            begin
                err_reg[k] <= err_reg[k-1];
            end
        end
    end

    bce_store #(
        .POINT_COUNT (POINT_COUNT)
    ) u_store (
        .clk        (clk),
        .adv        (adv),
        .wr_en      (wr_en),
        .wr_index   (point_index),
        .wr_point   (point_value),
        .rd_base    (base_index),
        .rd_degree  (degree),
        .rd_error   (index_error),
        .term_coord (term_coord)
    );

    bce_weights u_weights (
        .clk     (clk),
        .adv     (adv),
        .u_param (u_param),
        .degree  (degree),
        .weight  (weight)
    );

    // One blend path per axis
    for (genvar a = 0; a < AXES; a++) begin : g_axis
        logic [TERMS-1:0][COORD_W-1:0] axis_coord;
        coord_t                        axis_point;

        for (genvar i = 0; i < TERMS; i++) begin : g_term
            assign axis_coord[i] = term_coord[i][a];
        end

        bce_blend u_blend (
            .clk      (clk),
            .adv      (adv),
            .coord_in (axis_coord),
            .weight   (weight),
            .clear    (err_reg[STAGES-1]),
            .point    (axis_point)
        );

        assign m_tdata[a*COORD_W +: COORD_W] = axis_point;
    end

    assign m_tvalid = valid_reg[STAGES];
    assign m_tuser  = err_reg[STAGES];

    // Checks on pipeline control
    `BCE_ASSERT_IMPLY(a_error_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0,
        "error result with nonzero point")
    `BCE_ASSERT_NEXT(a_write_bubble, clk, rst_n, in_xfer && (s_tuser == OP_WRITE),
        !valid_reg[1], "write transfer entered the pipeline")
    `BCE_ASSERT_NEXT(a_eval_enters, clk, rst_n, in_xfer && (s_tuser == OP_EVAL),
        valid_reg[1], "evaluate transfer lost at entry")
    `BCE_ASSERT_IMPLY(a_ready_full, clk, rst_n, !s_tready, valid_reg[1] && !en[2],
        "input stalled with a free first stage")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier curve point evaluator testbench
// Loads 3D control points into the store, then streams evaluate items across
// every degree at varied segment positions and parameter values. A scoreboard
// tracks the store contents and works out each Bernstein point exactly. Both
// stream sides idle at random.
// ----------------------------------------------------------------------------

module tb;

    import bce_pkg::*;

    localparam int POINT_COUNT  = DEFAULT_POINT_COUNT;
    localparam int RANDOM_ITEMS = 550;
    localparam int MAX_REPORTS  = 40;

    // One slave-side item before packing
    typedef struct {
        logic                op;
        logic [INDEX_W-1:0]  point_index;
        coord_t              x_value;
        coord_t              y_value;
        coord_t              z_value;
        logic [DEGREE_W-1:0] degree;
        logic [INDEX_W-1:0]  base_index;
        logic [U_W-1:0]      u_param;
    } curve_item_t;

    // One predicted curve point
    typedef struct {
        coord_t x_point;
        coord_t y_point;
        coord_t z_point;
        logic   index_error;
    } curve_point_t;

    // ------------------------------------------------------------------------
    // Scoreboard: control point store copy and pending curve points
    // ------------------------------------------------------------------------
    class curve_point_board;
        coord_t       point_store [POINT_COUNT][AXES];
        curve_point_t pending_points [$];
        int           mismatch_count;

        function int bernstein_coeff(logic [DEGREE_W-1:0] deg, int term);
            if (deg == DEG_CUBIC && (term == 1 || term == 2))
                return 3;
            if (deg == DEG_QUAD && term == 1)
                return 2;
            return 1;
        endfunction

        // Exact weighted sum in offset binary, rounded half up at 2^-48
        function coord_t blend_axis(weight_t wts [TERMS], coord_t pts [TERMS], int terms);
            logic [79:0] acc;
            logic [79:0] rounded;
            acc = '0;
            for (int i = 0; i < terms; i++)
                acc += 80'(pts[i] ^ COORD_SIGN) * 80'(wts[i]);
            rounded = (acc + (80'(1) << 47)) >> 48;
            if (rounded > 80'hFFFFFF)
                rounded = 80'hFFFFFF;
            return rounded[COORD_W-1:0] ^ COORD_SIGN;
        endfunction

        // Note an accepted slave transfer: update the store or predict a point
        function void note_item(logic op, logic [S_TDATA_W-1:0] data);
            logic [INDEX_W-1:0]  idx;
            logic [DEGREE_W-1:0] deg;
            logic [INDEX_W-1:0]  base;
            logic [U_W-1:0]      u_raw;
            logic [63:0]         uu;
            logic [63:0]         vv;
            logic [63:0]         upow [TERMS];
            logic [63:0]         vpow [TERMS];
            weight_t             wts [TERMS];
            coord_t              pts [TERMS];
            coord_t              axis_val [AXES];
            curve_point_t        pt;
            idx   = data[OFS_INDEX +: INDEX_W];
            deg   = data[OFS_DEG +: DEGREE_W];
            base  = data[OFS_BASE +: INDEX_W];
            u_raw = data[OFS_U +: U_W];
            if (op == OP_WRITE)
            begin
                if (int'(idx) < POINT_COUNT)
                begin
                    point_store[idx][0] = data[OFS_X +: COORD_W];
                    point_store[idx][1] = data[OFS_Y +: COORD_W];
                    point_store[idx][2] = data[OFS_Z +: COORD_W];
                end
                return;
            end
            if (int'(base) + int'(deg) >= POINT_COUNT)
            begin
                pt = '{x_point: '0, y_point: '0, z_point: '0, index_error: 1'b1};
                pending_points = {pending_points, pt};
                return;
            end
            // Clamp u to one, then form the Bernstein weights scaled to 2^48
            uu = (u_raw > U_ONE) ? 64'(U_ONE) : 64'(u_raw);
            vv = 64'(U_ONE) - uu;
            upow[0] = 64'd1;
            vpow[0] = 64'd1;
            for (int i = 1; i < TERMS; i++)
            begin
                upow[i] = upow[i-1] * uu;
                vpow[i] = vpow[i-1] * vv;
            end
            for (int i = 0; i < TERMS; i++)
            begin
                wts[i] = '0;
                if (i <= int'(deg))
                    wts[i] = weight_t'((64'(bernstein_coeff(deg, i)) * upow[i]
                             * vpow[int'(deg) - i]) << (16 * (3 - int'(deg))));
            end
            for (int a = 0; a < AXES; a++)
            begin
                for (int i = 0; i < TERMS; i++)
                    pts[i] = (i <= int'(deg)) ? point_store[int'(base) + i][a] : '0;
                axis_val[a] = blend_axis(wts, pts, int'(deg) + 1);
            end
            pt = '{x_point: axis_val[0], y_point: axis_val[1], z_point: axis_val[2],
                   index_error: 1'b0};
            pending_points = {pending_points, pt};
        endfunction

        task report(string what, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("MISMATCH %s: got %h, expected %h", what, got, want);
        endtask

        // Check an accepted master transfer against the oldest prediction
        task check_point(logic [M_TDATA_W-1:0] data, logic flag);
            curve_point_t want;
            if (pending_points.size() == 0)
            begin
                report("result with none pending", data[COORD_W-1:0], '0);
                return;
            end
            want = pending_points.pop_front();
            if (data[0 +: COORD_W] !== want.x_point)
                report("x_point", data[0 +: COORD_W], want.x_point);
            if (data[COORD_W +: COORD_W] !== want.y_point)
                report("y_point", data[COORD_W +: COORD_W], want.y_point);
            if (data[2*COORD_W +: COORD_W] !== want.z_point)
                report("z_point", data[2*COORD_W +: COORD_W], want.z_point);
            if (flag !== want.index_error)
                report("index_error", COORD_W'(flag), COORD_W'(want.index_error));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    curve_point_board board = new();
    int               burst_left;
    int               stall_mode;
    int               stall_phase;

    bezier_curve_point_evaluator #(
        .POINT_COUNT(POINT_COUNT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // Observe transfers on both sides at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                board.check_point(m_tdata, m_tuser);
        end
    end

    // Receiver backpressure under a randomly chosen stall pattern
    always @(negedge clk)
    begin
        stall_phase++;
        if (stall_phase % 50 == 0)
            stall_mode = int'($urandom_range(0, 3));
        case (stall_mode)
            0: m_tready = 1'b1;
            1: m_tready = 1'($urandom_range(0, 1));
            2: m_tready = (stall_phase % 4 != 3);
            default: m_tready = (stall_phase % 16) < 4;
        endcase
    end

    // Random item: every field random, including those the operation ignores
    function curve_item_t random_item();
        curve_item_t it;
        it.op          = 1'($urandom_range(0, 1));
        it.point_index = INDEX_W'($urandom);
        it.x_value     = COORD_W'($urandom);
        it.y_value     = COORD_W'($urandom);
        it.z_value     = COORD_W'($urandom);
        it.degree      = DEGREE_W'($urandom);
        it.base_index  = INDEX_W'($urandom);
        it.u_param     = U_W'($urandom);
        return it;
    endfunction

    function coord_t edge_coord();
        case ($urandom_range(0, 4))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Drive one item at the falling edge and hold until its transfer
    task send_item(curve_item_t it);
        logic [S_TDATA_W-1:0] packed_bits;
        int gap;
        packed_bits = '0;
        packed_bits[OFS_INDEX +: INDEX_W] = it.point_index;
        packed_bits[OFS_X +: COORD_W]     = it.x_value;
        packed_bits[OFS_Y +: COORD_W]     = it.y_value;
        packed_bits[OFS_Z +: COORD_W]     = it.z_value;
        packed_bits[OFS_DEG +: DEGREE_W]  = it.degree;
        packed_bits[OFS_BASE +: INDEX_W]  = it.base_index;
        packed_bits[OFS_U +: U_W]         = it.u_param;
        s_tdata  = packed_bits;
        s_tuser  = it.op;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        // End of burst: drop valid for a random gap, then pick the next burst
        burst_left--;
        if (burst_left <= 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                gap = 0;
                burst_left = int'($urandom_range(20, 60));
            end
            else
            begin
                gap = int'($urandom_range(1, 6));
                burst_left = int'($urandom_range(1, 8));
            end
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task send_write(logic [INDEX_W-1:0] idx, coord_t x, coord_t y, coord_t z);
        curve_item_t it;
        it = random_item();
        it.op          = OP_WRITE;
        it.point_index = idx;
        it.x_value     = x;
        it.y_value     = y;
        it.z_value     = z;
        send_item(it);
    endtask

    task send_eval(logic [DEGREE_W-1:0] deg, logic [INDEX_W-1:0] base, logic [U_W-1:0] u);
        curve_item_t it;
        it = random_item();
        it.op         = OP_EVAL;
        it.degree     = deg;
        it.base_index = base;
        it.u_param    = u;
        send_item(it);
    endtask

    // Global watchdog
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int          sent;
        int          kind;
        int          count;
        int          base;
        int          step;
        int          u_acc;
        logic [1:0]  deg;
        curve_item_t it;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_WRITE;
        burst_left  = 4;
        stall_mode  = 0;
        stall_phase = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: load every entry, extremes in the first points
        send_write(4'd0, 24'h7FFFFF, 24'h800000, 24'h000000);
        send_write(4'd1, 24'h800000, 24'h7FFFFF, 24'hFFFFFF);
        send_write(4'd2, 24'h000100, 24'hFFFF00, 24'h7FFFFF);
        send_write(4'd3, 24'hFFFFFF, 24'h000001, 24'h800000);
        for (int i = 4; i < POINT_COUNT; i++)
            send_write(i[INDEX_W-1:0], edge_coord(), edge_coord(), edge_coord());

        // Directed: each degree, parameter ends, segment edges of the store
        send_eval(DEG_POINT, 4'd0, 17'd0);
        send_eval(DEG_LINEAR, 4'd0, U_ONE);
        send_eval(DEG_LINEAR, 4'd0, 17'h08000);
        send_eval(DEG_QUAD, 4'd2, 17'h1FFFF);
        send_eval(DEG_CUBIC, 4'd12, 17'h04000);
        send_eval(DEG_CUBIC, 4'd13, 17'd1);
        send_eval(DEG_LINEAR, 4'd15, 17'd0);
        send_eval(DEG_POINT, 4'd15, 17'hFFFF);
        send_eval(DEG_QUAD, 4'd14, 17'h0C000);

        // Random: mostly tessellation runs, with point updates and noise
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            kind = int'($urandom_range(0, 9));
            if (kind <= 5)
            begin
                deg   = 2'($urandom_range(0, 3));
                base  = int'($urandom_range(0, 12));
                step  = int'($urandom_range(256, 32768));
                count = int'($urandom_range(4, 16));
                u_acc = 0;
                for (int k = 0; k < count; k++)
                begin
                    send_eval(deg, base[INDEX_W-1:0], u_acc[U_W-1:0]);
                    sent++;
                    // Step u; at the segment end move the base along by degree, or by one for a point
                    if (u_acc == int'(U_ONE))
                    begin
                        u_acc = 0;
                        base += (deg == DEG_POINT) ? 1 : int'(deg);
                    end
                    else if (u_acc + step > int'(U_ONE))
                    begin
                        u_acc = int'(U_ONE);
                    end
                    else
                    begin
                        u_acc += step;
                    end
                end
            end
            else if (kind <= 7)
            begin
                count = int'($urandom_range(1, 4));
                for (int k = 0; k < count; k++)
                begin
                    send_write(INDEX_W'($urandom), COORD_W'($urandom),
                               COORD_W'($urandom), COORD_W'($urandom));
                    sent++;
                end
            end
            else if (kind == 8)
            begin
                it = random_item();
                it.op = OP_EVAL;
                send_item(it);
                sent++;
            end
            else
            begin
                send_write(INDEX_W'($urandom), edge_coord(), edge_coord(), edge_coord());
                sent++;
            end
        end
        s_tvalid = 1'b0;

        // Drain outstanding points, then allow for pipeline latency
        while (board.pending_points.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
